// File: rtl/core/cle_pkg.sv
// Shared command/status codes, sequencer states and control bundles for the list engine.
package cle_pkg;

	// Fixed width of the data ports.
	localparam int DATA_W = 32;

	// Command codes.
	localparam logic [2:0] CMD_INS_HEAD = 3'd0;
	localparam logic [2:0] CMD_APPEND   = 3'd1;
	localparam logic [2:0] CMD_FIRST    = 3'd2;
	localparam logic [2:0] CMD_NEXT     = 3'd3;
	localparam logic [2:0] CMD_REMOVE   = 3'd4;
	localparam logic [2:0] CMD_COUNT    = 3'd5;

	// Status codes.
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_EMPTY  = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_BADCUR = 2'd3;

	// Sequencer states, one-hot.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_A    = 3'b010,
		ST_B    = 3'b100
	} state_t;

	// Node memory strobes.
	typedef struct packed {
		logic rd_en;
		logic val_we;
		logic link_we;
	} nm_ctl_t;

	// Free-node stack strobes.
	typedef struct packed {
		logic pop;
		logic push;
	} fs_ctl_t;

endpackage

// File: rtl/core/circular_list_engine.sv
// Sequencing: count and every refused command give done from ST_IDLE, registered at the accept edge;
// remove and insert into an empty list finish in ST_A; other inserts, first and next in ST_B.
// A new command is taken only once the previous one is done (busy); the node memory's single registered
// read port sets the pace, as each linked step waits on the previous read.
// done pulses for one cycle and cannot be held off. Reset (arst_n low) empties the
// list at once: no clearing pass, the free stack uses a low watermark instead.
module circular_list_engine #(
	parameter int CAPACITY    = 64,
	parameter int VALUE_WIDTH = 32,
	localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    cmd,
	input  logic signed [cle_pkg::DATA_W-1:0] data_in,
	output logic                          done,
	output logic [1:0]                    status,
	output logic signed [cle_pkg::DATA_W-1:0] data_out,
	output logic [CNT_W-1:0]              item_count
);
	import cle_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

	// sequencer and list registers
	state_t             state_q;
	logic [2:0]         cmd_q;
	logic [VALUE_WIDTH-1:0] din_q;
	logic [IDX_W-1:0]   tail_q;     // tail node; its link is the head
	logic [IDX_W-1:0]   cur_q;
	logic [IDX_W-1:0]   prev_q;     // predecessor of the cursor
	logic [IDX_W-1:0]   node_q;     // node popped by an insert
	logic               cur_valid_q;
	logic               can_rm_q;   // cursor is fresh from first/next
	logic [CNT_W-1:0]   total_q;

	// result word
	logic               done_q;
	logic [1:0]         status_q;
	logic [DATA_W-1:0]  dout_q;
	logic [CNT_W-1:0]   cnt_q;

	// memory hookup
	nm_ctl_t            nm_ctl;
	logic [IDX_W-1:0]   nm_rd_addr;
	logic [IDX_W-1:0]   nm_wr_addr;
	logic [VALUE_WIDTH-1:0] nm_wr_val;
	logic [IDX_W-1:0]   nm_wr_link;
	logic [VALUE_WIDTH-1:0] nm_rd_val;
	logic [IDX_W-1:0]   nm_rd_link;
	fs_ctl_t            fs_ctl;
	logic [IDX_W-1:0]   fs_pos_rd;
	logic [IDX_W-1:0]   fs_pos_wr;
	logic [IDX_W-1:0]   fs_rd_data;

	// decode and helpers
	logic               accept;
	logic [1:0]         pre_stat;
	logic               mem_cmd;     // command needs the memories
	logic               cmd_ins;     // insert on the input port
	logic               q_ins;       // insert in flight
	logic [CNT_W-1:0]   pop_full;
	logic [CNT_W-1:0]   push_full;
	logic [VALUE_WIDTH-1:0] din_st;
	logic [DATA_W-1:0]  val_ext;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign done       = done_q;
	assign status     = status_q;
	assign data_out   = dout_q;
	assign item_count = cnt_q;

	assign cmd_ins = (cmd == CMD_INS_HEAD) || (cmd == CMD_APPEND);
	assign q_ins   = (cmd_q == CMD_INS_HEAD) || (cmd_q == CMD_APPEND);

	// stack slots: pop from CAPACITY-1-total, push at CAPACITY-total
	assign pop_full  = CAP_C - total_q - CNT_W'(1);
	assign push_full = CAP_C - total_q;
	assign fs_pos_rd = pop_full[IDX_W-1:0];
	assign fs_pos_wr = push_full[IDX_W-1:0];

	// values are sign-extended or truncated to VALUE_WIDTH on store and to 32 bits on read
	generate
		if (VALUE_WIDTH >= DATA_W) begin : g_wide
			assign din_st  = {{(VALUE_WIDTH - DATA_W){data_in[DATA_W-1]}}, data_in};
			assign val_ext = nm_rd_val[DATA_W-1:0];
		end else begin : g_narrow
			assign din_st  = data_in[VALUE_WIDTH-1:0];
			assign val_ext = {{(DATA_W - VALUE_WIDTH){nm_rd_val[VALUE_WIDTH-1]}}, nm_rd_val};
		end
	endgenerate

	// Misuse checks need only the registers, so they resolve on the accept edge.
	always_comb begin
		pre_stat = STAT_OK;
		mem_cmd  = 1'b0;
		unique case (cmd)
			CMD_INS_HEAD, CMD_APPEND: begin
				if (total_q == CAP_C) pre_stat = STAT_FULL;
				else mem_cmd = 1'b1;
			end
			CMD_FIRST: begin
				if (total_q == '0) pre_stat = STAT_EMPTY;
				else mem_cmd = 1'b1;
			end
			CMD_NEXT: begin
				if (total_q == '0) pre_stat = STAT_EMPTY;
				else if (!cur_valid_q) pre_stat = STAT_BADCUR;
				else mem_cmd = 1'b1;
			end
			CMD_REMOVE: begin
				if (total_q == '0) pre_stat = STAT_EMPTY;
				else if (!(can_rm_q && cur_valid_q)) pre_stat = STAT_BADCUR;
				else mem_cmd = 1'b1;
			end
			default: begin
				// count, and the unused codes behave as count
				mem_cmd = 1'b0;
			end
		endcase
	end

	// Memory port steering. The node memory is the shared unit: one read and one
	// write per cycle, reused by the memory steps of every command that needs it.
	always_comb begin
		nm_ctl     = '0;
		nm_rd_addr = cur_q;
		nm_wr_addr = prev_q;
		nm_wr_val  = din_q;
		nm_wr_link = nm_rd_link;
		fs_ctl     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && mem_cmd) begin
					// insert/first start from the tail's link, next/remove from the cursor
					nm_ctl.rd_en = 1'b1;
					nm_rd_addr   = (cmd_ins || cmd == CMD_FIRST) ? tail_q : cur_q;
					fs_ctl.pop   = cmd_ins;
				end
			end
			ST_A: begin
				if (q_ins) begin
					// new node links to the old head, or to itself in an empty list
					nm_ctl.val_we  = 1'b1;
					nm_ctl.link_we = 1'b1;
					nm_wr_addr     = fs_rd_data;
					nm_wr_link     = (total_q == '0) ? fs_rd_data : nm_rd_link;
				end else if (cmd_q == CMD_REMOVE) begin
					// bypass the cursor node and return it to the stack
					fs_ctl.push    = 1'b1;
					nm_ctl.link_we = (total_q != CNT_W'(1));
					nm_wr_addr     = prev_q;
					nm_wr_link     = nm_rd_link;
				end else begin
					// first/next: fetch the value of the new cursor
					nm_ctl.rd_en = 1'b1;
					nm_rd_addr   = nm_rd_link;
				end
			end
			ST_B: begin
				if (q_ins) begin
					nm_ctl.link_we = 1'b1;
					nm_wr_addr     = tail_q;
					nm_wr_link     = node_q;
				end
			end
			default: begin
				nm_ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			din_q <= din_st;
		end
		if (state_q == ST_A) begin
			node_q <= fs_rd_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tail_q      <= '0;
			cur_q       <= '0;
			prev_q      <= '0;
			cur_valid_q <= 1'b0;
			can_rm_q    <= 1'b0;
			total_q     <= '0;
			done_q      <= 1'b0;
			status_q    <= STAT_OK;
			dout_q      <= '0;
			cnt_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mem_cmd) begin
							state_q <= ST_A;
						end else begin
							// refused command or count: answer right away
							done_q   <= 1'b1;
							status_q <= pre_stat;
							dout_q   <= '0;
							cnt_q    <= total_q;
						end
					end
				end
				ST_A: begin
					if (q_ins) begin
						if (total_q == '0) begin
							tail_q   <= fs_rd_data;
							total_q  <= total_q + CNT_W'(1);
							can_rm_q <= 1'b0;
							done_q   <= 1'b1;
							status_q <= STAT_OK;
							dout_q   <= '0;
							cnt_q    <= total_q + CNT_W'(1);
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_B;
						end
					end else if (cmd_q == CMD_REMOVE) begin
						if (total_q == CNT_W'(1)) begin
							tail_q      <= '0;
							cur_q       <= '0;
							prev_q      <= '0;
							cur_valid_q <= 1'b0;
						end else begin
							if (cur_q == tail_q) tail_q <= prev_q;
							cur_q <= prev_q;
						end
						total_q  <= total_q - CNT_W'(1);
						can_rm_q <= 1'b0;
						done_q   <= 1'b1;
						status_q <= STAT_OK;
						dout_q   <= val_ext;
						cnt_q    <= total_q - CNT_W'(1);
						state_q  <= ST_IDLE;
					end else begin
						// first steps from the tail, next from the cursor
						prev_q  <= (cmd_q == CMD_FIRST) ? tail_q : cur_q;
						cur_q   <= nm_rd_link;
						state_q <= ST_B;
					end
				end
				ST_B: begin
					if (q_ins) begin
						if (cmd_q == CMD_APPEND) tail_q <= node_q;
						total_q  <= total_q + CNT_W'(1);
						can_rm_q <= 1'b0;
						dout_q   <= '0;
						cnt_q    <= total_q + CNT_W'(1);
					end else begin
						cur_valid_q <= 1'b1;
						can_rm_q    <= 1'b1;
						dout_q      <= val_ext;
						cnt_q       <= total_q;
					end
					done_q   <= 1'b1;
					status_q <= STAT_OK;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	cle_node_mem #(
		.DEPTH (CAPACITY),
		.IDX_W (IDX_W),
		.VAL_W (VALUE_WIDTH)
	) u_node_mem (
		.clk     (clk),
		.ctl     (nm_ctl),
		.rd_addr (nm_rd_addr),
		.wr_addr (nm_wr_addr),
		.wr_val  (nm_wr_val),
		.wr_link (nm_wr_link),
		.rd_val  (nm_rd_val),
		.rd_link (nm_rd_link)
	);

	cle_free_stack #(
		.DEPTH (CAPACITY),
		.IDX_W (IDX_W),
		.CNT_W (CNT_W)
	) u_free_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (fs_ctl),
		.pos_rd  (fs_pos_rd),
		.pos_wr  (fs_pos_wr),
		.wr_data (cur_q),
		.rd_data (fs_rd_data)
	);

endmodule

// File: rtl/core/cle_node_mem.sv
// Node memory: value and link per node, one write and one registered read per cycle.
module cle_node_mem #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6,
	parameter int VAL_W = 32
) (
	input  logic                  clk,
	input  cle_pkg::nm_ctl_t      ctl,
	input  logic [IDX_W-1:0]      rd_addr,
	input  logic [IDX_W-1:0]      wr_addr,
	input  logic [VAL_W-1:0]      wr_val,
	input  logic [IDX_W-1:0]      wr_link,
	output logic [VAL_W-1:0]      rd_val,
	output logic [IDX_W-1:0]      rd_link
);
	import cle_pkg::*;

	logic [VAL_W-1:0] val_mem [DEPTH];
	logic [IDX_W-1:0] link_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.val_we) begin
			val_mem[wr_addr] <= wr_val;
		end
		if (ctl.link_we) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (ctl.rd_en) begin
			rd_val  <= val_mem[rd_addr];
			rd_link <= link_mem[rd_addr];
		end
	end

endmodule

// File: rtl/core/cle_free_stack.sv
// Free-node stack with a low watermark standing in for the all-free reset contents.
module cle_free_stack #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6,
	parameter int CNT_W = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cle_pkg::fs_ctl_t      ctl,
	input  logic [IDX_W-1:0]      pos_rd,
	input  logic [IDX_W-1:0]      pos_wr,
	input  logic [IDX_W-1:0]      wr_data,
	output logic [IDX_W-1:0]      rd_data
);
	import cle_pkg::*;

	logic [IDX_W-1:0] stk_mem [DEPTH];
	logic [IDX_W-1:0] mem_rd_q;
	logic [IDX_W-1:0] pos_q;
	logic             fresh_q;
	// slots below the watermark were never written and still hold their own index
	logic [CNT_W-1:0] low_q;
	logic             below;

	assign below   = CNT_W'(pos_rd) < low_q;
	assign rd_data = fresh_q ? pos_q : mem_rd_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			stk_mem[pos_wr] <= wr_data;
		end
		if (ctl.pop) begin
			mem_rd_q <= stk_mem[pos_rd];
			pos_q    <= pos_rd;
			fresh_q  <= below;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q <= CNT_W'(DEPTH);
		end else if (ctl.pop && below) begin
			low_q <= CNT_W'(pos_rd);
		end
	end

endmodule

// File: rtl/core/cle_checker.sv
// Port-level checks for the list engine, bound to the top level.
module cle_checker #(
	parameter int CAPACITY = 64,
	parameter int CNT_W    = 7
) (
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             done,
	input logic [1:0]       status,
	input logic [CNT_W-1:0] item_count
);
	import cle_pkg::*;

	// a result word only shows while the engine is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done while busy");

	// an accepted word either answers at once or keeps the engine busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted word dropped");

	// a full report only comes with a full list
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_FULL) |-> (item_count == CNT_W'(CAPACITY)))
		else $error("full reported below capacity");

	// an empty report only comes with an empty list
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STAT_EMPTY) |-> (item_count == '0))
		else $error("empty reported with nodes present");

endmodule

bind circular_list_engine cle_checker #(
	.CAPACITY (CAPACITY),
	.CNT_W    (CNT_W)
) u_cle_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.item_count (item_count)
);

// File: sim/circular_list_engine_checker.sv
// Checker for the list engine: mirrors the list, predicts each result word, compares.
module circular_list_engine_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              busy,
	input  logic [2:0]                        cmd,
	input  logic signed [cle_pkg::DATA_W-1:0] data_in,
	input  logic                              done,
	input  logic [1:0]                        status,
	input  logic signed [cle_pkg::DATA_W-1:0] data_out,
	input  logic [6:0]                        item_count,
	output int                                fail_count,
	output int                                pending,
	output int                                list_size
);
	import cle_pkg::*;

	localparam int NODES = 64;
	localparam int IDX_W = 6;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [DATA_W-1:0] data;
		logic [6:0]               count;
	} list_word_t;

	// mirror of the node memory and list pointers
	logic signed [DATA_W-1:0] node_val [NODES];
	logic [IDX_W-1:0]         node_next [NODES];
	logic [IDX_W-1:0]         spare_nodes [NODES];
	int                       spare_top;
	logic [IDX_W-1:0]         tail_node;
	logic [IDX_W-1:0]         cur_node;
	logic [IDX_W-1:0]         prev_node;
	bit                       cur_set;
	bit                       may_remove;
	int                       node_cnt;
	list_word_t               awaiting[$];

	function automatic list_word_t apply_word(input logic [2:0] op,
			input logic signed [DATA_W-1:0] val);
		list_word_t       r;
		logic [IDX_W-1:0] n;
		r.status = STAT_OK;
		r.data = '0;
		case (op)
		CMD_INS_HEAD, CMD_APPEND: begin
			if (spare_top == 0) begin
				r.status = STAT_FULL;
			end else begin
				spare_top--;
				n = spare_nodes[spare_top];
				node_val[n] = val;
				if (node_cnt == 0) begin
					node_next[n] = n;
					tail_node = n;
				end else begin
					node_next[n] = node_next[tail_node];
					node_next[tail_node] = n;
					if (op == CMD_APPEND)
						tail_node = n;
				end
				node_cnt++;
				may_remove = 1'b0;
			end
		end
		CMD_FIRST: begin
			if (node_cnt == 0) begin
				r.status = STAT_EMPTY;
			end else begin
				prev_node = tail_node;
				cur_node = node_next[tail_node];
				cur_set = 1'b1;
				may_remove = 1'b1;
				r.data = node_val[cur_node];
			end
		end
		CMD_NEXT: begin
			if (node_cnt == 0) begin
				r.status = STAT_EMPTY;
			end else if (!cur_set) begin
				r.status = STAT_BADCUR;
			end else begin
				prev_node = cur_node;
				cur_node = node_next[cur_node];
				may_remove = 1'b1;
				r.data = node_val[cur_node];
			end
		end
		CMD_REMOVE: begin
			if (node_cnt == 0) begin
				r.status = STAT_EMPTY;
			end else if (!may_remove || !cur_set) begin
				r.status = STAT_BADCUR;
			end else begin
				n = cur_node;
				r.data = node_val[n];
				if (node_cnt == 1) begin
					tail_node = '0;
					cur_node = '0;
					prev_node = '0;
					cur_set = 1'b0;
				end else begin
					if (n == tail_node)
						tail_node = prev_node;
					node_next[prev_node] = node_next[n];
					cur_node = prev_node;
				end
				spare_nodes[spare_top] = n;
				spare_top++;
				node_cnt--;
				may_remove = 1'b0;
			end
		end
		default: ; // count and the spare codes only report the size
		endcase
		r.count = 7'(node_cnt);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_word_t want;
		if (!arst_n) begin
			for (int i = 0; i < NODES; i++)
				spare_nodes[i] = IDX_W'(i);
			spare_top = NODES;
			tail_node = '0;
			cur_node = '0;
			prev_node = '0;
			cur_set = 1'b0;
			may_remove = 1'b0;
			node_cnt = 0;
			awaiting.delete();
			fail_count = 0;
			pending <= 0;
			list_size <= 0;
		end else begin
			if (done) begin
				if (awaiting.size() == 0) begin
					$error("result word with no command outstanding");
					fail_count++;
				end else begin
					want = awaiting.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fail_count++;
					end
					if (data_out !== want.data) begin
						$error("data_out: expected %0d, got %0d", want.data, data_out);
						fail_count++;
					end
					if (item_count !== want.count) begin
						$error("item_count: expected %0d, got %0d", want.count, item_count);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				awaiting.push_back(apply_word(cmd, data_in));
			pending <= awaiting.size();
			list_size <= node_cnt;
		end
	end

endmodule

// File: sim/tb_circular_list_engine.sv
// Testbench top for the circular list engine: stimulus, watchdog and verdict.
module tb_circular_list_engine;
	import cle_pkg::*;

	localparam int NODES          = 64;
	localparam int RANDOM_WORDS   = 1920;
	localparam int CALM_WORDS     = 300;   // tail of the run with no sender gaps
	localparam int WATCHDOG_LIMIT = 2000;  // cycles with neither accept nor result
	localparam int DRAIN_CYCLES   = 8;     // margin after the longest command, which runs through ST_A and ST_B

	// unused opcodes, the engine treats them as count
	localparam logic [2:0] CMD_SPARE6 = 3'd6;
	localparam logic [2:0] CMD_SPARE7 = 3'd7;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [2:0]               cmd = CMD_COUNT;
	logic signed [DATA_W-1:0] data_in = '0;
	logic                     done;
	logic [1:0]               status;
	logic signed [DATA_W-1:0] data_out;
	logic [6:0]               item_count;

	int fail_count;
	int pending;
	int list_size;
	int stall_cycles;

	// random walk state: size the list is steered toward, how long to
	// linger there, and whether the cursor was just placed by first/next
	int goal;
	int linger;
	bit fresh;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	circular_list_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.data_in   (data_in),
		.done      (done),
		.status    (status),
		.data_out  (data_out),
		.item_count(item_count)
	);

	circular_list_engine_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.data_in   (data_in),
		.done      (done),
		.status    (status),
		.data_out  (data_out),
		.item_count(item_count),
		.fail_count(fail_count),
		.pending   (pending),
		.list_size (list_size)
	);

	// Watchdog: any accepted command or result word restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one command word and hold it until the engine takes it.
	// busy is sampled at the edge itself, i.e. the value the engine sees.
	task automatic send_word(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
		start <= 1'b1;
		cmd <= op;
		data_in <= val;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Hold off until every outstanding result word has come back.
	// pending is registered, so skip the edge where the last word went in.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Data mix: corner values a fifth of the time, otherwise full random.
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 19))
		0: return 32'h7fff_ffff;
		1: return 32'h8000_0000;
		2: return 32'h0000_0000;
		3: return 32'hffff_ffff;
		default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_insert();
		return $urandom_range(0, 1) ? CMD_APPEND : CMD_INS_HEAD;
	endfunction

	// Random command: steer the list size toward a goal (full and empty
	// included), linger there walking the ring, then pick a new goal.
	// Removes mostly follow a first/next so they actually unlink nodes.
	// About one word in eight is pure noise over all eight opcodes.
	function automatic void pick_word(output logic [2:0] op,
			output logic signed [DATA_W-1:0] val);
		int roll;
		if (linger == 0) begin
			case ($urandom_range(0, 3))
			0: goal = NODES;
			1: goal = 0;
			default: goal = $urandom_range(1, NODES - 1);
			endcase
			linger = $urandom_range(10, 60);
		end
		roll = $urandom_range(0, 99);
		val = pick_value();
		if (roll < 12) begin
			op = 3'($urandom_range(0, 7));
		end else if (list_size < goal) begin
			op = (roll < 85) ? pick_insert() : CMD_NEXT;
		end else if (list_size > goal) begin
			if (fresh)
				op = (roll < 80) ? CMD_REMOVE : CMD_NEXT;
			else
				op = (roll < 70) ? CMD_NEXT : CMD_FIRST;
		end else begin
			// at the goal: walk the ring; inserts at full give the full status
			linger--;
			if (roll < 35)
				op = CMD_NEXT;
			else if (roll < 50)
				op = CMD_FIRST;
			else if (roll < 60)
				op = CMD_COUNT;
			else if (roll < 75)
				op = fresh ? CMD_REMOVE : CMD_NEXT;
			else
				op = pick_insert();
		end
		if (op == CMD_FIRST || op == CMD_NEXT)
			fresh = 1'b1;
		else if (op == CMD_INS_HEAD || op == CMD_APPEND || op == CMD_REMOVE)
			fresh = 1'b0;
	endfunction

	initial begin
		logic [2:0]               op;
		logic signed [DATA_W-1:0] val;
		bit                       calm;
		goal = 0;
		linger = 0;
		fresh = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: count, first, next and remove on an empty list first
		send_word(CMD_COUNT, '0);
		send_word(CMD_FIRST, '0);
		send_word(CMD_NEXT, '0);
		send_word(CMD_REMOVE, '0);
		// one node, cursor never placed: next and remove are refused
		send_word(CMD_INS_HEAD, 32'h7fff_ffff);
		send_word(CMD_NEXT, '0);
		send_word(CMD_REMOVE, '0);
		// grow at both ends with the data extremes
		send_word(CMD_APPEND, 32'h8000_0000);
		send_word(CMD_INS_HEAD, 32'h0000_0000);
		send_word(CMD_APPEND, 32'hffff_ffff);
		// walk and unlink; a second remove without moving is refused
		send_word(CMD_FIRST, 32'hffff_ffff);
		send_word(CMD_NEXT, '0);
		send_word(CMD_REMOVE, '0);
		send_word(CMD_REMOVE, '0);
		send_word(CMD_NEXT, '0);
		// an insert cancels the remove permission but keeps the cursor
		send_word(CMD_INS_HEAD, 32'h5555_5555);
		send_word(CMD_REMOVE, '0);
		send_word(CMD_NEXT, '0);
		send_word(CMD_REMOVE, '0);
		// spare opcodes behave as count
		send_word(CMD_SPARE6, 32'haaaa_aaaa);
		send_word(CMD_SPARE7, '0);
		// three nodes left: drain, the last remove empties the list
		repeat (3) begin
			send_word(CMD_FIRST, '0);
			send_word(CMD_REMOVE, '0);
		end
		send_word(CMD_NEXT, '0);
		send_word(CMD_COUNT, '0);

		// sender stops until the engine has answered everything
		settle();

		// Random part
		for (int k = 0; k < RANDOM_WORDS; k++) begin
			calm = (k >= RANDOM_WORDS - CALM_WORDS);
			if (!calm && $urandom_range(0, 99) < 15) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else if (!calm && $urandom_range(0, 249) == 0) begin
				settle();
			end
			pick_word(op, val);
			send_word(op, val);
		end

		// end of run: collect the outstanding words, then watch for strays
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
